>>> rtl/euler_to_dcm_321_defines.svh
// ----------------------------------------------------------------------------
// euler_to_dcm_321_defines
// Assertion macros shared by the RTL files of the attitude matrix block.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_DCM_321_DEFINES_SVH
`define EULER_TO_DCM_321_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside of reset.
`define E2D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside of reset.
`define E2D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/e2d_pkg.sv
// ----------------------------------------------------------------------------
// e2d_pkg
// Types, constants and the arctangent table of the 3-2-1 attitude matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package e2d_pkg;

	localparam int ANGLE_BITS_DEF     = 16;
	localparam int COEF_FRAC_BITS_DEF = 14;
	localparam int FIELD_W            = 16;
	localparam int TRIG_W             = 32;
	localparam int PHASE_W            = 34;
	localparam int SUM_W              = 34;
	localparam int CORDIC_STEPS       = 30;
	localparam int LANES              = 3;
	localparam int LANE_ROLL          = 0;
	localparam int LANE_PITCH         = 1;
	localparam int LANE_YAW           = 2;

	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

	// Arctangent of 2^-i in units of 2^-32 turn.
	localparam logic [31:0] ATAN_TURN32 [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	typedef struct packed {
		logic [FIELD_W-1:0] roll_angle;
		logic [FIELD_W-1:0] pitch_angle;
		logic [FIELD_W-1:0] yaw_angle;
	} angles_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] c11;
		logic signed [FIELD_W-1:0] c12;
		logic signed [FIELD_W-1:0] c13;
		logic signed [FIELD_W-1:0] c21;
		logic signed [FIELD_W-1:0] c22;
		logic signed [FIELD_W-1:0] c23;
		logic signed [FIELD_W-1:0] c31;
		logic signed [FIELD_W-1:0] c32;
		logic signed [FIELD_W-1:0] c33;
	} dcm_t;

	typedef logic [LANES-1:0][TRIG_W-1:0] trig_t;

	// Product of two Q30 values rounded back to Q30, ties upward.
	function automatic logic signed [TRIG_W-1:0] mulq(input logic signed [TRIG_W-1:0] a,
			input logic signed [TRIG_W-1:0] b);
		logic signed [2*TRIG_W-1:0] p;
		p = a * b;
		p = p + 64'sd536870912;
		return p[61:30];
	endfunction

endpackage

`default_nettype wire

>>> rtl/e2d_cordic.sv
// ----------------------------------------------------------------------------
// e2d_cordic
// Three-lane pipelined CORDIC giving Q30 sine and cosine, one step per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module e2d_cordic #(
	parameter int ANGLE_BITS = e2d_pkg::ANGLE_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire logic                                   in_valid,
	input  wire logic [e2d_pkg::LANES-1:0][e2d_pkg::FIELD_W-1:0] ang,
	output logic                                        out_valid,
	output e2d_pkg::trig_t                              sn,
	output e2d_pkg::trig_t                              cs
);

	localparam int STEPS = e2d_pkg::CORDIC_STEPS;
	localparam int TW    = e2d_pkg::TRIG_W;
	localparam int ZW    = e2d_pkg::PHASE_W;
	localparam int SHIFT = 32 - ANGLE_BITS;
	localparam logic [31:0] AMASK = (ANGLE_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << ANGLE_BITS) - 64'd1);

	logic signed [TW-1:0] x_s  [STEPS][e2d_pkg::LANES];
	logic signed [TW-1:0] y_s  [STEPS][e2d_pkg::LANES];
	logic signed [ZW-1:0] z_s  [STEPS][e2d_pkg::LANES];
	logic                 f_s  [STEPS][e2d_pkg::LANES];
	logic [STEPS-1:0]     v_s;

	logic signed [TW-1:0] sn_s31 [e2d_pkg::LANES];
	logic signed [TW-1:0] cs_s31 [e2d_pkg::LANES];
	logic                 v_s31;

	logic signed [ZW-1:0] z0   [e2d_pkg::LANES];
	logic                 f0   [e2d_pkg::LANES];

	// Fold the phase into the right half plane; a folded angle negates both results.
	always_comb begin
		logic [31:0] ph;
		for (int l = 0; l < e2d_pkg::LANES; l++) begin
			ph = ({16'b0, ang[l]} & AMASK) << SHIFT;
			f0[l] = ph[31] ^ ph[30];
			if (f0[l]) begin
				ph = ph - 32'h8000_0000;
			end
			z0[l] = ZW'($signed(ph));
		end
	end

	genvar i;
	generate
		for (i = 0; i < STEPS; i++) begin : g_step
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[i] <= 1'b0;
				end else if (en) begin
					v_s[i] <= (i == 0) ? in_valid : v_s[(i == 0) ? 0 : i-1];
				end
			end

			always_ff @(posedge clk) begin
				logic signed [TW-1:0] xp, yp;
				logic signed [ZW-1:0] zp, at;
				logic                 fp;
				if (en) begin
					for (int l = 0; l < e2d_pkg::LANES; l++) begin
						if (i == 0) begin
							xp = e2d_pkg::CORDIC_GAIN;
							yp = '0;
							zp = z0[l];
							fp = f0[l];
						end else begin
							xp = x_s[(i == 0) ? 0 : i-1][l];
							yp = y_s[(i == 0) ? 0 : i-1][l];
							zp = z_s[(i == 0) ? 0 : i-1][l];
							fp = f_s[(i == 0) ? 0 : i-1][l];
						end
						at = ZW'(e2d_pkg::ATAN_TURN32[i]);
						if (zp >= 0) begin
							x_s[i][l] <= xp - (yp >>> i);
							y_s[i][l] <= yp + (xp >>> i);
							z_s[i][l] <= zp - at;
						end else begin
							x_s[i][l] <= xp + (yp >>> i);
							y_s[i][l] <= yp - (xp >>> i);
							z_s[i][l] <= zp + at;
						end
						f_s[i][l] <= fp;
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s31 <= 1'b0;
		end else if (en) begin
			v_s31 <= v_s[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < e2d_pkg::LANES; l++) begin
				sn_s31[l] <= f_s[STEPS-1][l] ? -y_s[STEPS-1][l] : y_s[STEPS-1][l];
				cs_s31[l] <= f_s[STEPS-1][l] ? -x_s[STEPS-1][l] : x_s[STEPS-1][l];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < e2d_pkg::LANES; l++) begin
			sn[l] = sn_s31[l];
			cs[l] = cs_s31[l];
		end
	end

	assign out_valid = v_s31;

endmodule

`default_nettype wire

>>> rtl/e2d_prod.sv
// ----------------------------------------------------------------------------
// e2d_prod
// Three-stage product, sum and rounding pipeline forming the nine entries.
// ----------------------------------------------------------------------------
`default_nettype none

module e2d_prod #(
	parameter int COEF_FRAC_BITS = e2d_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire e2d_pkg::trig_t sn,
	input  wire e2d_pkg::trig_t cs,
	output logic                out_valid,
	output e2d_pkg::dcm_t       out_dcm
);

	localparam int TW = e2d_pkg::TRIG_W;
	localparam int SW = e2d_pkg::SUM_W;
	localparam int SH = 30 - COEF_FRAC_BITS;
	localparam logic signed [SW:0] HALF = (SH > 0) ?
		((SW+1)'(1) <<< ((SH > 0) ? SH-1 : 0)) : '0;
	localparam logic signed [SW:0] LIM = (SW+1)'(1) <<< COEF_FRAC_BITS;

	// Round a Q30 sum to the coefficient format and clamp it to plus or minus one.
	function automatic logic [e2d_pkg::FIELD_W-1:0] to_coef(input logic signed [SW-1:0] v);
		logic signed [SW:0] r;
		r = ($signed({v[SW-1], v}) + HALF) >>> SH;
		if (r > LIM) begin
			r = LIM;
		end
		if (r < -LIM) begin
			r = -LIM;
		end
		return r[e2d_pkg::FIELD_W-1:0];
	endfunction

	logic signed [TW-1:0] sr, cr, sp, cp, sy, cy;
	assign sr = $signed(sn[e2d_pkg::LANE_ROLL]);
	assign cr = $signed(cs[e2d_pkg::LANE_ROLL]);
	assign sp = $signed(sn[e2d_pkg::LANE_PITCH]);
	assign cp = $signed(cs[e2d_pkg::LANE_PITCH]);
	assign sy = $signed(sn[e2d_pkg::LANE_YAW]);
	assign cy = $signed(cs[e2d_pkg::LANE_YAW]);

	logic                 v_s1, v_s2, v_s3;
	logic signed [TW-1:0] cysp_s1, sysp_s1, p11_s1, p12_s1, sycr_s1, cycr_s1;
	logic signed [TW-1:0] p23_s1, sysr_s1, cysr_s1, p33_s1, sr_s1, cr_s1;
	logic signed [SW-1:0] nsp_s1;
	logic signed [TW-1:0] a21_s2, a22_s2, a31_s2, a32_s2;
	logic signed [TW-1:0] p11_s2, p12_s2, sycr_s2, cycr_s2, p23_s2, sysr_s2, cysr_s2, p33_s2;
	logic signed [SW-1:0] nsp_s2;
	e2d_pkg::dcm_t        dcm_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cysp_s1 <= e2d_pkg::mulq(cy, sp);
			sysp_s1 <= e2d_pkg::mulq(sy, sp);
			p11_s1  <= e2d_pkg::mulq(cy, cp);
			p12_s1  <= e2d_pkg::mulq(sy, cp);
			sycr_s1 <= e2d_pkg::mulq(sy, cr);
			cycr_s1 <= e2d_pkg::mulq(cy, cr);
			p23_s1  <= e2d_pkg::mulq(cp, sr);
			sysr_s1 <= e2d_pkg::mulq(sy, sr);
			cysr_s1 <= e2d_pkg::mulq(cy, sr);
			p33_s1  <= e2d_pkg::mulq(cp, cr);
			sr_s1   <= sr;
			cr_s1   <= cr;
			nsp_s1  <= -SW'(sp);

			a21_s2  <= e2d_pkg::mulq(cysp_s1, sr_s1);
			a22_s2  <= e2d_pkg::mulq(sysp_s1, sr_s1);
			a31_s2  <= e2d_pkg::mulq(cysp_s1, cr_s1);
			a32_s2  <= e2d_pkg::mulq(sysp_s1, cr_s1);
			p11_s2  <= p11_s1;
			p12_s2  <= p12_s1;
			sycr_s2 <= sycr_s1;
			cycr_s2 <= cycr_s1;
			p23_s2  <= p23_s1;
			sysr_s2 <= sysr_s1;
			cysr_s2 <= cysr_s1;
			p33_s2  <= p33_s1;
			nsp_s2  <= nsp_s1;

			dcm_s3.c11 <= to_coef(SW'(p11_s2));
			dcm_s3.c12 <= to_coef(SW'(p12_s2));
			dcm_s3.c13 <= to_coef(nsp_s2);
			dcm_s3.c21 <= to_coef(SW'(a21_s2) - SW'(sycr_s2));
			dcm_s3.c22 <= to_coef(SW'(a22_s2) + SW'(cycr_s2));
			dcm_s3.c23 <= to_coef(SW'(p23_s2));
			dcm_s3.c31 <= to_coef(SW'(a31_s2) + SW'(sysr_s2));
			dcm_s3.c32 <= to_coef(SW'(a32_s2) - SW'(cysr_s2));
			dcm_s3.c33 <= to_coef(SW'(p33_s2));
		end
	end

	assign out_valid = v_s3;
	assign out_dcm   = dcm_s3;

endmodule

`default_nettype wire

>>> rtl/euler_to_dcm_321.sv
// ----------------------------------------------------------------------------
// euler_to_dcm_321
// Yaw-pitch-roll (3-2-1) Euler angles to direction cosine matrix, pipelined.
// ----------------------------------------------------------------------------
// Usage:
// The angles channel (angles_valid, angles_stall, angles) takes one word of
// roll, pitch and yaw binary angles; the dcm channel (dcm_valid, dcm_stall,
// dcm) returns one word of nine signed Q2.14 entries in row-major order.
// A word moves when valid is high and stall is low at a rising clock edge.
// From the accepting edge a word passes through 35 registers (31 CORDIC
// stages, three product and rounding stages and the output register).
// Throughput is one word per cycle while the receiver does not stall, set by
// the one-step-per-stage CORDIC and the fully pipelined multipliers.
// A receiver stall first parks one word in a skid register; angles_stall then
// rises, the whole pipeline holds, and no word is lost or repeated. When the
// receiver resumes, the parked word goes out first.
// Reset (arst_n low) empties the pipeline, the skid register and the output;
// there is no other state and no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "euler_to_dcm_321_defines.svh"

module euler_to_dcm_321 #(
	parameter int ANGLE_BITS     = e2d_pkg::ANGLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = e2d_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       angles_valid,
	output logic            angles_stall,
	input  wire e2d_pkg::angles_t angles,
	output logic            dcm_valid,
	input  wire logic       dcm_stall,
	output e2d_pkg::dcm_t   dcm
);

	logic                en;
	logic                cv;
	e2d_pkg::trig_t      sn, cs;
	logic                pv;
	e2d_pkg::dcm_t       pdat;
	logic                skid_v_q, out_v_q;
	e2d_pkg::dcm_t       skid_q, out_q;
	logic [e2d_pkg::LANES-1:0][e2d_pkg::FIELD_W-1:0] ang;

	assign en           = !skid_v_q;
	assign angles_stall = skid_v_q;

	always_comb begin
		ang[e2d_pkg::LANE_ROLL]  = angles.roll_angle;
		ang[e2d_pkg::LANE_PITCH] = angles.pitch_angle;
		ang[e2d_pkg::LANE_YAW]   = angles.yaw_angle;
	end

	e2d_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (angles_valid),
		.ang      (ang),
		.out_valid(cv),
		.sn       (sn),
		.cs       (cs)
	);

	e2d_prod #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (cv),
		.sn       (sn),
		.cs       (cs),
		.out_valid(pv),
		.out_dcm  (pdat)
	);

	// The output register drains the skid word before the pipeline moves again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !dcm_stall) begin
			if (skid_v_q) begin
				out_q    <= skid_q;
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_q   <= pdat;
				out_v_q <= pv;
			end
		end else if (!skid_v_q && pv) begin
			skid_q   <= pdat;
			skid_v_q <= 1'b1;
		end
	end

	assign dcm_valid = out_v_q;
	assign dcm       = out_q;

	`E2D_ASSERT_NOW(a_skid_implies_out, skid_v_q, out_v_q, "skid word held without an output word")
	`E2D_ASSERT_NEXT(a_stall_parks, out_v_q && dcm_stall && pv && !skid_v_q, skid_v_q, "pipeline word not parked on stall")
	`E2D_ASSERT_NOW(a_skid_rise, $rose(skid_v_q), $past(dcm_stall), "skid filled without a receiver stall")

endmodule

`default_nettype wire
